// ----- rtl/core/cpru_pkg.sv -----
`default_nettype none

package cpru_pkg;

    // size limits of the datapath
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_FACTOR = 8;

    // register field widths as seen on the configuration port
    localparam int CFG_DIM_W  = 12;
    localparam int CFG_POS_W  = 11;
    localparam int CFG_F_W    = 4;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    // internal widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int XDIM_W = COL_W + 1;
    localparam int YDIM_W = ROW_W + 1;
    localparam int RROW_W = $clog2(MAX_FACTOR);
    localparam int FCNT_W = $clog2(MAX_FACTOR + 1);
    localparam int PIX_W  = 24;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_WIN_X        = 3'd2,
        REG_WIN_Y        = 3'd3,
        REG_WIN_WIDTH    = 3'd4,
        REG_WIN_HEIGHT   = 3'd5,
        REG_SCALE_FACTOR = 3'd6
    } cfg_idx_t;

    // effective (clamped) configuration
    typedef struct packed {
        logic [XDIM_W-1:0] iw;
        logic [YDIM_W-1:0] ih;
        logic [XDIM_W-1:0] win_x;
        logic [YDIM_W-1:0] win_y;
        logic [XDIM_W-1:0] ww;
        logic [YDIM_W-1:0] wh;
        logic [FCNT_W-1:0] f;
    } cfg_t;

    // one request for the replicator: a pixel repeated cnt times
    typedef struct packed {
        logic              use_ram;
        logic [PIX_W-1:0]  pix;
        logic [FCNT_W-1:0] cnt;
        logic              re;
        logic              fe;
        logic              ov;
    } desc_t;

endpackage

`default_nettype wire

// ----- rtl/core/cpru_regs.sv -----
`default_nettype none

module cpru_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cpru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cpru_pkg::CFG_DATA_W-1:0]    cfg_data,
    output cpru_pkg::cfg_t                          cfg
);

    localparam int XW = cpru_pkg::XDIM_W;
    localparam int YW = cpru_pkg::YDIM_W;
    localparam int FW = cpru_pkg::FCNT_W;

    logic [cpru_pkg::CFG_DIM_W-1:0] image_width_reg;
    logic [cpru_pkg::CFG_DIM_W-1:0] image_height_reg;
    logic [cpru_pkg::CFG_POS_W-1:0] win_x_reg;
    logic [cpru_pkg::CFG_POS_W-1:0] win_y_reg;
    logic [cpru_pkg::CFG_DIM_W-1:0] win_width_reg;
    logic [cpru_pkg::CFG_DIM_W-1:0] win_height_reg;
    logic [cpru_pkg::CFG_F_W-1:0]   scale_factor_reg;

    assign cfg_ready = 1'b1;

    // register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 12'd2048;
            image_height_reg <= 12'd2048;
            win_x_reg        <= '0;
            win_y_reg        <= '0;
            win_width_reg    <= 12'd2048;
            win_height_reg   <= 12'd2048;
            scale_factor_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cpru_pkg::cfg_idx_t'(cfg_index))
                cpru_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= cfg_data[cpru_pkg::CFG_DIM_W-1:0];
                cpru_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[cpru_pkg::CFG_DIM_W-1:0];
                cpru_pkg::REG_WIN_X:
                    win_x_reg <= cfg_data[cpru_pkg::CFG_POS_W-1:0];
                cpru_pkg::REG_WIN_Y:
                    win_y_reg <= cfg_data[cpru_pkg::CFG_POS_W-1:0];
                cpru_pkg::REG_WIN_WIDTH:
                    win_width_reg <= cfg_data[cpru_pkg::CFG_DIM_W-1:0];
                cpru_pkg::REG_WIN_HEIGHT:
                    win_height_reg <= cfg_data[cpru_pkg::CFG_DIM_W-1:0];
                cpru_pkg::REG_SCALE_FACTOR:
                    scale_factor_reg <= cfg_data[cpru_pkg::CFG_F_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp sizes to the buffer limits; a window origin past the limit never matches
    always_comb
    begin
        cfg.iw = (32'(image_width_reg) > cpru_pkg::MAX_WIDTH) ?
                 XW'(cpru_pkg::MAX_WIDTH) : XW'(image_width_reg);
        cfg.ih = (32'(image_height_reg) > cpru_pkg::MAX_HEIGHT) ?
                 YW'(cpru_pkg::MAX_HEIGHT) : YW'(image_height_reg);
        cfg.ww = (32'(win_width_reg) > cpru_pkg::MAX_WIDTH) ?
                 XW'(cpru_pkg::MAX_WIDTH) : XW'(win_width_reg);
        cfg.wh = (32'(win_height_reg) > cpru_pkg::MAX_HEIGHT) ?
                 YW'(cpru_pkg::MAX_HEIGHT) : YW'(win_height_reg);
        cfg.win_x = (32'(win_x_reg) > cpru_pkg::MAX_WIDTH) ?
                    XW'(cpru_pkg::MAX_WIDTH) : XW'(win_x_reg);
        cfg.win_y = (32'(win_y_reg) > cpru_pkg::MAX_HEIGHT) ?
                    YW'(cpru_pkg::MAX_HEIGHT) : YW'(win_y_reg);
        if (scale_factor_reg == '0)
            cfg.f = FW'(1);
        else if (32'(scale_factor_reg) > cpru_pkg::MAX_FACTOR)
            cfg.f = FW'(cpru_pkg::MAX_FACTOR);
        else
            cfg.f = FW'(scale_factor_reg);
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpru_front.sv -----
`default_nettype none

module cpru_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cpru_pkg::cfg_t                 cfg,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           mode,
    input  wire logic [7:0]                     pix_blue,
    input  wire logic [7:0]                     pix_green,
    input  wire logic [7:0]                     pix_red,
    input  wire logic                           take,
    output logic                                desc_valid,
    output cpru_pkg::desc_t                     desc,
    output logic [cpru_pkg::PIX_W-1:0]          ram_data
);

    localparam int XW = cpru_pkg::XDIM_W;
    localparam int YW = cpru_pkg::YDIM_W;
    localparam int CW = cpru_pkg::COL_W;
    localparam int RW = cpru_pkg::ROW_W;
    localparam int QW = cpru_pkg::RROW_W;
    localparam int FW = cpru_pkg::FCNT_W;

    // line store, undefined until written
    logic [cpru_pkg::PIX_W-1:0] line_mem [cpru_pkg::MAX_WIDTH];
    logic [cpru_pkg::PIX_W-1:0] rd_data_reg;

    logic [CW-1:0] src_col_reg, src_col_next;
    logic [RW-1:0] src_row_reg, src_row_next;
    logic [QW-1:0] repeat_row_reg, repeat_row_next;
    logic [CW-1:0] repeat_col_reg, repeat_col_next;
    logic          repeat_pending_reg, repeat_pending_next;
    logic          last_band_reg, last_band_next;
    logic          d_valid_reg, d_valid_next;
    cpru_pkg::desc_t d_reg, d_new;

    logic          accept;
    logic          produce;
    logic          wr_en;
    logic          rd_en;
    logic          pull_last;
    logic          pull_done;
    logic [XW-1:0] cx_full;
    logic [YW-1:0] ry_full;
    logic          in_window;
    logic          src_row_last;
    logic          band_last;
    logic          col_wrap;
    logic          row_wrap;
    logic [cpru_pkg::PIX_W-1:0] in_pix;

    assign accept   = in_valid && in_ready;
    assign in_ready = !d_valid_reg || take;
    assign in_pix   = {pix_red, pix_green, pix_blue};

    // position decode against the window
    always_comb
    begin
        pull_last = (XW'(repeat_col_reg) + XW'(1)) >= cfg.ww;
        pull_done = pull_last &&
                    ((FW+1)'(repeat_row_reg) + (FW+1)'(2)) >= (FW+1)'(cfg.f);
        cx_full   = XW'(src_col_reg) - cfg.win_x;
        ry_full   = YW'(src_row_reg) - cfg.win_y;
        in_window = (XW'(src_col_reg) >= cfg.win_x) && (cx_full < cfg.ww) &&
                    (YW'(src_row_reg) >= cfg.win_y) && (ry_full < cfg.wh);
        src_row_last = (cx_full + XW'(1)) == cfg.ww;
        band_last    = (ry_full + YW'(1)) == cfg.wh;
        col_wrap     = (XW'(src_col_reg) + XW'(1)) >= cfg.iw;
        row_wrap     = (YW'(src_row_reg) + YW'(1)) >= cfg.ih;
    end

    // next state and request build
    always_comb
    begin
        src_col_next        = src_col_reg;
        src_row_next        = src_row_reg;
        repeat_row_next     = repeat_row_reg;
        repeat_col_next     = repeat_col_reg;
        repeat_pending_next = repeat_pending_reg;
        last_band_next      = last_band_reg;
        produce             = 1'b0;
        wr_en               = 1'b0;
        rd_en               = 1'b0;
        d_new.use_ram       = 1'b0;
        d_new.pix           = '0;
        d_new.cnt           = cfg.f;
        d_new.re            = 1'b0;
        d_new.fe            = 1'b0;
        d_new.ov            = 1'b0;

        if (accept)
        begin
            if (mode)
            begin
                // pull one stored pixel of a repeated row
                if (repeat_pending_reg)
                begin
                    produce       = 1'b1;
                    rd_en         = 1'b1;
                    d_new.use_ram = 1'b1;
                    d_new.re      = pull_last;
                    d_new.fe      = pull_done && last_band_reg;
                    if (pull_last)
                    begin
                        repeat_col_next = '0;
                        if (pull_done)
                        begin
                            repeat_pending_next = 1'b0;
                            repeat_row_next     = '0;
                        end
                        else
                        begin
                            repeat_row_next = repeat_row_reg + QW'(1);
                        end
                    end
                    else
                    begin
                        repeat_col_next = repeat_col_reg + CW'(1);
                    end
                end
            end
            else if (repeat_pending_reg)
            begin
                // source pixel dropped
                produce   = 1'b1;
                d_new.cnt = FW'(1);
                d_new.ov  = 1'b1;
            end
            else
            begin
                if (in_window)
                begin
                    produce   = 1'b1;
                    wr_en     = 1'b1;
                    d_new.pix = in_pix;
                    d_new.re  = src_row_last;
                    d_new.fe  = src_row_last && band_last && (cfg.f == FW'(1));
                    if (src_row_last && (cfg.f > FW'(1)))
                    begin
                        repeat_pending_next = 1'b1;
                        repeat_row_next     = '0;
                        repeat_col_next     = '0;
                        last_band_next      = band_last;
                    end
                end
                // step the source raster position
                if (col_wrap)
                begin
                    src_col_next = '0;
                    src_row_next = row_wrap ? '0 : src_row_reg + RW'(1);
                end
                else
                begin
                    src_col_next = src_col_reg + CW'(1);
                end
            end
        end

        if (produce)
            d_valid_next = 1'b1;
        else if (take)
            d_valid_next = 1'b0;
        else
            d_valid_next = d_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg        <= '0;
            src_row_reg        <= '0;
            repeat_row_reg     <= '0;
            repeat_col_reg     <= '0;
            repeat_pending_reg <= 1'b0;
            last_band_reg      <= 1'b0;
            d_valid_reg        <= 1'b0;
        end
        else
        begin
            src_col_reg        <= src_col_next;
            src_row_reg        <= src_row_next;
            repeat_row_reg     <= repeat_row_next;
            repeat_col_reg     <= repeat_col_next;
            repeat_pending_reg <= repeat_pending_next;
            last_band_reg      <= last_band_next;
            d_valid_reg        <= d_valid_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (produce)
            d_reg <= d_new;
    end

    // line store: at most one write or one read per request, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[cx_full[CW-1:0]] <= in_pix;
        if (rd_en)
            rd_data_reg <= line_mem[repeat_col_reg];
    end

    assign desc_valid = d_valid_reg;
    assign desc       = d_reg;
    assign ram_data   = rd_data_reg;

    // idle repeat counters sit at zero
    a_repeat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !repeat_pending_reg |-> (repeat_row_reg == '0) && (repeat_col_reg == '0))
        else $error("repeat counters not cleared while idle");

    // a waiting request is not lost or altered
    a_desc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && !take |=> d_valid_reg && $stable(d_reg))
        else $error("pending request changed before hand-off");

    // overrun requests carry one plain copy
    a_overrun_desc: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && d_reg.ov |-> (d_reg.cnt == FW'(1)) && !d_reg.use_ram)
        else $error("overrun request malformed");

endmodule

`default_nettype wire

// ----- rtl/core/cpru_emit.sv -----
`default_nettype none

module cpru_emit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       desc_valid,
    input  wire cpru_pkg::desc_t            desc,
    input  wire logic [cpru_pkg::PIX_W-1:0] ram_data,
    output logic                            take,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [7:0]                      out_blue,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_red,
    output logic                            row_end,
    output logic                            frame_end,
    output logic                            overrun
);

    localparam int FW = cpru_pkg::FCNT_W;

    logic                       e_valid_reg, e_valid_next;
    logic [FW-1:0]              e_left_reg, e_left_next;
    logic [cpru_pkg::PIX_W-1:0] e_pix_reg;
    logic                       e_re_reg;
    logic                       e_fe_reg;
    logic                       e_ov_reg;
    logic                       e_last;

    assign e_last = e_left_reg == FW'(1);
    assign take   = desc_valid && (!e_valid_reg || (out_ready && e_last));

    // copy counter
    always_comb
    begin
        e_valid_next = e_valid_reg;
        e_left_next  = e_left_reg;
        if (take)
        begin
            e_valid_next = 1'b1;
            e_left_next  = desc.cnt;
        end
        else if (e_valid_reg && out_ready)
        begin
            if (e_last)
                e_valid_next = 1'b0;
            else
                e_left_next = e_left_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            e_left_reg  <= '0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            e_left_reg  <= e_left_next;
        end
    end

    // pixel and flags of the request being replicated
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            e_pix_reg <= desc.use_ram ? ram_data : desc.pix;
            e_re_reg  <= desc.re;
            e_fe_reg  <= desc.fe;
            e_ov_reg  <= desc.ov;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_blue  = e_pix_reg[7:0];
    assign out_green = e_pix_reg[15:8];
    assign out_red   = e_pix_reg[23:16];
    assign row_end   = e_re_reg && e_last;
    assign frame_end = e_fe_reg && e_last;
    assign overrun   = e_ov_reg;

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> e_left_reg != '0)
        else $error("active request with no copies left");

    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    a_overrun_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overrun |-> (out_blue == 8'd0) && (out_green == 8'd0) &&
        (out_red == 8'd0) && !row_end && !frame_end)
        else $error("overrun result not blank");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> e_valid_reg)
        else $error("request taken but not presented");

endmodule

`default_nettype wire

// ----- rtl/core/crop_and_pixel_replicate_upscale_core.sv -----
`default_nettype none

// channel   direction  handshake               payload
// in        sink       in_valid / in_ready     mode, pix_blue, pix_green, pix_red
// out       source     out_valid / out_ready   out_blue, out_green, out_red,
//                                              row_end, frame_end, overrun
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a kept pixel or a pull is sent scale_factor times, an overrun once; a request that
// yields nothing is accepted without output. the first result passes the request
// register, then the replicator register; the next request is taken while the current
// one is replicated. out_ready low holds the replicator and, once the request register
// is full, drops in_ready. pulls read the line store through a registered read; no
// clearing pass after reset, the store is undefined until written. cfg_ready is high.

module crop_and_pixel_replicate_upscale_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             mode,
    input  wire logic [7:0]                       pix_blue,
    input  wire logic [7:0]                       pix_green,
    input  wire logic [7:0]                       pix_red,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [7:0]                            out_blue,
    output logic [7:0]                            out_green,
    output logic [7:0]                            out_red,
    output logic                                  row_end,
    output logic                                  frame_end,
    output logic                                  overrun,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cpru_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cpru_pkg::CFG_DATA_W-1:0]  cfg_data
);

    cpru_pkg::cfg_t             cfg;
    cpru_pkg::desc_t            desc;
    logic                       desc_valid;
    logic                       take;
    logic [cpru_pkg::PIX_W-1:0] ram_data;

    // configuration registers
    cpru_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // position tracking and line store
    cpru_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .pix_blue   (pix_blue),
        .pix_green  (pix_green),
        .pix_red    (pix_red),
        .take       (take),
        .desc_valid (desc_valid),
        .desc       (desc),
        .ram_data   (ram_data)
    );

    // horizontal replication and output register
    cpru_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .ram_data   (ram_data),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .row_end    (row_end),
        .frame_end  (frame_end),
        .overrun    (overrun)
    );

endmodule

`default_nettype wire
